// ===== rtl/core/erle_pkg.sv =====
// ----------------------------------------------------------------------------
// erle_pkg
// Shared types and constants of the escape-coded run-length byte decoder.
// ----------------------------------------------------------------------------
package erle_pkg;

  localparam int BYTES_PER_RESULT = 4;
  localparam int LEN_W            = 17;
  localparam int CNT_W            = 3;

  localparam logic [7:0]       ESCAPE_BYTE      = 8'hED;
  localparam logic [LEN_W-1:0] BLOCK_LEN_RESET  = 17'd16384;
  localparam logic [CNT_W-1:0] LANES_FULL       = 3'(BYTES_PER_RESULT);

  // escape phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ONE   = 2'd1;
  localparam logic [1:0] PH_COUNT = 2'd2;
  localparam logic [1:0] PH_VALUE = 2'd3;

  typedef logic [BYTES_PER_RESULT-1:0][7:0] lanes_t;

  typedef struct packed {
    lanes_t           out_bytes;
    logic [CNT_W-1:0] byte_count;
    logic             last_of_run;
    logic             block_done;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic step;
  } erle_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
    logic more;
  } erle_sts_t;

endpackage

// ===== rtl/core/erle_ifs.sv =====
// ----------------------------------------------------------------------------
// erle channel interfaces
// Compressed byte request channel and packed result channel.
// ----------------------------------------------------------------------------
interface erle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first_of_block;

  modport source (output valid, in_byte, first_of_block, input ready);
  modport sink   (input valid, in_byte, first_of_block, output ready);
endinterface

interface erle_out_if;
  import erle_pkg::*;
  logic             valid;
  logic             ready;
  logic [7:0]       out_byte0;
  logic [7:0]       out_byte1;
  logic [7:0]       out_byte2;
  logic [7:0]       out_byte3;
  logic [CNT_W-1:0] byte_count;
  logic             last_of_run;
  logic             block_done;

  modport source (output valid, out_byte0, out_byte1, out_byte2, out_byte3,
                  byte_count, last_of_run, block_done, input ready);
  modport sink   (input valid, out_byte0, out_byte1, out_byte2, out_byte3,
                  byte_count, last_of_run, block_done, output ready);
endinterface

// ===== rtl/core/erle_ctrl.sv =====
// ----------------------------------------------------------------------------
// erle_ctrl
// Controller: takes requests while no run is draining, steps run results.
// ----------------------------------------------------------------------------
module erle_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  erle_pkg::erle_sts_t sts,
  output erle_pkg::erle_cmd_t cmd
);
  import erle_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;

  assign in_ready   = (state == ST_IDLE) && sts.slot_free;
  assign cmd.accept = in_valid && in_ready;
  assign cmd.step   = (state == ST_RUN) && sts.slot_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept && sts.more) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.step && !sts.more) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

`ifndef NO_ASSERTIONS
  // a run keeps the input closed until its last result is loaded
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> !in_ready)
    else $error("request taken while a run drains");
  a_run_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && cmd.step && !sts.more) |=> (state == ST_IDLE))
    else $error("controller stayed in run after last result");
  a_enter_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && sts.more) |=> (state == ST_RUN))
    else $error("long run did not enter run state");
`endif

endmodule

// ===== rtl/core/erle_dp.sv =====
// ----------------------------------------------------------------------------
// erle_dp
// Datapath: escape state, block position, run count and the result register.
// ----------------------------------------------------------------------------
module erle_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [erle_pkg::LEN_W-1:0]        cfg_data,
  input  logic [7:0]                        in_byte,
  input  logic                              first_of_block,
  input  erle_pkg::erle_cmd_t               cmd,
  output erle_pkg::erle_sts_t               sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output erle_pkg::result_t                 res
);
  import erle_pkg::*;

  logic [LEN_W-1:0] block_length;
  logic [1:0]       phase;
  logic [7:0]       run_len;
  logic [LEN_W-1:0] pos;
  logic [7:0]       rem;
  logic [7:0]       rest_byte;

  logic [1:0]       phase_cur, phase_next;
  logic [7:0]       run_cur, run_next;
  logic [LEN_W-1:0] pos_cur;
  logic [7:0]       n_item, head_item, n_clamp;
  logic [LEN_W-1:0] avail;
  logic [7:0]       src_n, src_rest;
  logic [LEN_W-1:0] src_pos, new_pos;
  logic [CNT_W-1:0] lanes;
  logic [7:0]       rem_after;
  logic             load;
  lanes_t           bytes_next;

  assign phase_cur = first_of_block ? PH_IDLE : phase;
  assign run_cur   = first_of_block ? 8'd0 : run_len;
  assign pos_cur   = first_of_block ? '0 : pos;

  always_comb begin
    phase_next = phase_cur;
    run_next   = run_cur;
    n_item     = 8'd0;
    head_item  = in_byte;
    unique case (phase_cur)
      PH_IDLE: begin
        if (in_byte == ESCAPE_BYTE) phase_next = PH_ONE;
        else                        n_item     = 8'd1;
      end
      PH_ONE: begin
        if (in_byte == ESCAPE_BYTE) begin
          phase_next = PH_COUNT;
        end else begin
          n_item     = 8'd2;
          head_item  = ESCAPE_BYTE;
          phase_next = PH_IDLE;
        end
      end
      PH_COUNT: begin
        run_next   = in_byte;
        phase_next = PH_VALUE;
      end
      PH_VALUE: begin
        n_item     = run_cur;
        run_next   = 8'd0;
        phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // room left in the block, bytes past it are dropped
  assign avail   = (pos_cur < block_length) ? block_length - pos_cur : '0;
  assign n_clamp = ({{(LEN_W-8){1'b0}}, n_item} > avail) ? avail[7:0] : n_item;

  // one chunk generator serves the first result and the run results
  assign src_n    = cmd.accept ? n_clamp : rem;
  assign src_rest = cmd.accept ? in_byte : rest_byte;
  assign src_pos  = cmd.accept ? pos_cur : pos;
  assign lanes    = (src_n >= 8'(BYTES_PER_RESULT)) ? LANES_FULL : src_n[CNT_W-1:0];
  assign new_pos  = src_pos + LEN_W'(lanes);
  assign rem_after = src_n - 8'(lanes);
  assign load     = (cmd.accept && (n_clamp != 8'd0)) || cmd.step;

  always_comb begin
    for (int j = 0; j < BYTES_PER_RESULT; j++) begin
      if (j >= int'(lanes))            bytes_next[j] = 8'd0;
      else if (j == 0 && cmd.accept)   bytes_next[j] = head_item;
      else                             bytes_next[j] = src_rest;
    end
  end

  assign sts.slot_free = !out_valid || out_ready;
  assign sts.more      = (rem_after != 8'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= BLOCK_LEN_RESET;
      phase        <= PH_IDLE;
      run_len      <= 8'd0;
      pos          <= '0;
      rem          <= 8'd0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) block_length <= cfg_data;
      if (cmd.accept) begin
        phase <= phase_next;
        run_len <= run_next;
        pos     <= (n_clamp != 8'd0) ? new_pos : pos_cur;
        rem     <= (n_clamp != 8'd0) ? rem_after : 8'd0;
      end else if (cmd.step) begin
        pos <= new_pos;
        rem <= rem_after;
      end
      if (load)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) rest_byte <= in_byte;
    if (load) begin
      res.out_bytes   <= bytes_next;
      res.byte_count  <= lanes;
      res.last_of_run <= (rem_after == 8'd0);
      res.block_done  <= (new_pos >= block_length);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res.byte_count != 3'd0 && res.byte_count <= LANES_FULL))
    else $error("result lane count out of range");
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.last_of_run) |-> (rem != 8'd0))
    else $error("non-final result without pending bytes");
  a_idle_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> (rem == 8'd0))
    else $error("request taken before run drained");
  a_unused_lane: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.byte_count < LANES_FULL) |->
      (res.out_bytes[BYTES_PER_RESULT-1] == 8'd0))
    else $error("unused lane not cleared");
`endif

endmodule

// ===== rtl/core/escape_rle_byte_decoder_top.sv =====
// ----------------------------------------------------------------------------
// escape_rle_byte_decoder_top
// Escape-coded run-length byte decoder with packed four-byte results.
// ----------------------------------------------------------------------------
// Usage:
//   stream : compressed byte requests (in_byte, first_of_block), valid/ready.
//   result : up to four decoded bytes per result with byte_count,
//            last_of_run and block_done, valid/ready.
//   cfg_we / cfg_data : block_length, written while the decoder is idle.
// A request that yields bytes shows its first result in the cycle after it is
// taken. Literals and short escapes run at one request per cycle while the
// result side keeps up. A run of n bytes gives ceil(n/4) results, one per
// cycle while the result side keeps up; the input stays closed until the last
// one is loaded into the result register. Escape prefixes and count bytes
// give no result. Reset clears the escape state, position, run count and
// result valid flag and sets block_length to 16384. A stalled result holds
// its register and, through it, closes the input.
// ----------------------------------------------------------------------------
module escape_rle_byte_decoder_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [erle_pkg::LEN_W-1:0] cfg_data,
  erle_in_if.sink                    stream,
  erle_out_if.source                 result
);
  import erle_pkg::*;

  erle_cmd_t cmd;
  erle_sts_t sts;
  result_t   res;

  erle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stream.valid),
    .in_ready (stream.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  erle_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_byte        (stream.in_byte),
    .first_of_block (stream.first_of_block),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .res            (res)
  );

  assign result.out_byte0   = res.out_bytes[0];
  assign result.out_byte1   = res.out_bytes[1];
  assign result.out_byte2   = res.out_bytes[2];
  assign result.out_byte3   = res.out_bytes[3];
  assign result.byte_count  = res.byte_count;
  assign result.last_of_run = res.last_of_run;
  assign result.block_done  = res.block_done;

endmodule

// ===== bench/escape_rle_byte_decoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// escape_rle_byte_decoder_top_tb
// Drives compressed byte requests into the decoder and checks every packed
// result against a cycle-free model of the escape and run-length decoding,
// lane packing and block length cut-off, over several block lengths and
// idle patterns on both channels.
// ----------------------------------------------------------------------------
module escape_rle_byte_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import erle_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 34;

  // decodes requests into the packed results the block must produce
  class decoded_scoreboard;
    int         block_len;
    int         position;
    logic [1:0] phase;
    logic [7:0] held_count;
    result_t    pending[$];
    int         errors;
    int         results_seen;
    int         done_seen;

    function new();
      block_len = int'(BLOCK_LEN_RESET);
      clear_block();
      errors = 0;
      results_seen = 0;
      done_seen = 0;
    endfunction

    function void clear_block();
      position = 0;
      phase = PH_IDLE;
      held_count = 8'h00;
    endfunction

    function void set_length(logic [LEN_W-1:0] value);
      block_len = int'(value);
    endfunction

    function void take_request(logic [7:0] b, logic first);
      int         n;
      int         avail;
      int         k;
      int         lanes;
      logic [7:0] head;
      logic [7:0] rest;
      result_t    r;
      n = 0;
      head = 8'h00;
      rest = 8'h00;
      if (first) clear_block();
      case (phase)
        PH_IDLE: begin
          if (b == ESCAPE_BYTE) phase = PH_ONE;
          else begin
            n = 1;
            head = b;
            rest = b;
          end
        end
        PH_ONE: begin
          if (b == ESCAPE_BYTE) phase = PH_COUNT;
          else begin
            n = 2;
            head = ESCAPE_BYTE;
            rest = b;
            phase = PH_IDLE;
          end
        end
        PH_COUNT: begin
          held_count = b;
          phase = PH_VALUE;
        end
        default: begin
          n = int'(held_count);
          head = b;
          rest = b;
          held_count = 8'h00;
          phase = PH_IDLE;
        end
      endcase
      avail = (position < block_len) ? block_len - position : 0;
      if (n > avail) n = avail;
      k = 0;
      while (k < n) begin
        lanes = (n - k > BYTES_PER_RESULT) ? BYTES_PER_RESULT : n - k;
        for (int j = 0; j < BYTES_PER_RESULT; j++) begin
          if (j < lanes) r.out_bytes[j] = (k + j == 0) ? head : rest;
          else r.out_bytes[j] = 8'h00;
        end
        k += lanes;
        position += lanes;
        r.byte_count = CNT_W'(lanes);
        r.last_of_run = (k == n);
        r.block_done = (position >= block_len);
        pending.push_back(r);
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        if (errors < 10) begin
          $display("result %0d: %s expected %0h, got %0h", results_seen, name, want, got);
        end
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        if (errors < 10) begin
          $display("result %0d: no request pending, got count %0d byte0 %0h",
                   results_seen, got.byte_count, got.out_bytes[0]);
        end
        errors++;
      end else begin
        want = pending.pop_front();
        for (int j = 0; j < BYTES_PER_RESULT; j++) begin
          compare_field($sformatf("out_byte%0d", j), want.out_bytes[j], got.out_bytes[j]);
        end
        compare_field("byte_count", want.byte_count, got.byte_count);
        compare_field("last_of_run", want.last_of_run, got.last_of_run);
        compare_field("block_done", want.block_done, got.block_done);
      end
      if (got.block_done) done_seen++;
      results_seen++;
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_data;
  int               cycles = 0;
  int               send_idle_pct = 16;
  int               recv_idle_pct = 47;
  int               requests_sent = 0;
  int               runs_sent = 0;

  decoded_scoreboard sb = new();

  erle_in_if  stream_if();
  erle_out_if result_if();

  escape_rle_byte_decoder_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .stream   (stream_if),
    .result   (result_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_if.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  // inputs only move at the rising edge, so the falling edge sees what the next edge takes
  always @(negedge clk) begin
    result_t got;
    if (!rst && result_if.valid && result_if.ready) begin
      got.out_bytes[0] = result_if.out_byte0;
      got.out_bytes[1] = result_if.out_byte1;
      got.out_bytes[2] = result_if.out_byte2;
      got.out_bytes[3] = result_if.out_byte3;
      got.byte_count = result_if.byte_count;
      got.last_of_run = result_if.last_of_run;
      got.block_done = result_if.block_done;
      sb.check_result(got);
    end
  end

  task automatic send_request(input logic [7:0] b, input logic first);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      stream_if.valid <= 1'b0;
      @(posedge clk);
    end
    stream_if.valid <= 1'b1;
    stream_if.in_byte <= b;
    stream_if.first_of_block <= first;
    do begin
      @(negedge clk);
      taken = stream_if.ready;
      @(posedge clk);
    end while (!taken);
    sb.take_request(b, first);
    requests_sent++;
  endtask

  task automatic send_run(input logic first, input logic [7:0] count, input logic [7:0] value);
    send_request(ESCAPE_BYTE, first);
    send_request(ESCAPE_BYTE, 1'b0);
    send_request(count, 1'b0);
    send_request(value, 1'b0);
    runs_sent++;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == ESCAPE_BYTE);
    return b;
  endfunction

  task automatic send_random_stream(input int count);
    int         sent;
    int         kind;
    logic [7:0] run;
    logic       first;
    sent = 0;
    while (sent < count) begin
      first = ($urandom_range(7) == 0);
      kind = $urandom_range(99);
      if (kind < 35) begin
        send_request(plain_byte(), first);
        sent += 1;
      end else if (kind < 50) begin
        send_request(ESCAPE_BYTE, first);
        send_request(plain_byte(), 1'b0);
        sent += 2;
      end else if (kind < 85) begin
        // mostly short runs, now and then a long one that fills many results
        run = ($urandom_range(4) == 0) ? 8'($urandom_range(255, 13)) : 8'($urandom_range(12));
        send_run(first, run, 8'($urandom_range(255)));
        sent += 4;
      end else begin
        send_request(8'($urandom_range(255)), $urandom_range(15) == 0);
        sent += 1;
      end
    end
  endtask

  task automatic settle();
    stream_if.valid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_block_length(input logic [LEN_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_length(value);
  endtask

  initial begin
    logic [LEN_W-1:0] lengths[PHASES];
    lengths = '{17'd1, 17'd9, 17'd0, 17'd23, 17'h1FFFF, 17'd6, 17'd65536, 17'd57, 17'd200};
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    stream_if.valid <= 1'b0;
    stream_if.in_byte <= 8'h00;
    stream_if.first_of_block <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // literals, short escapes, runs of zero and full length, escape byte as data
    send_request(8'h00, 1'b1);
    send_request(8'hFF, 1'b0);
    send_request(ESCAPE_BYTE, 1'b0);
    send_request(8'h00, 1'b0);
    send_run(1'b0, 8'h00, 8'h55);
    send_run(1'b0, 8'hFF, 8'hAA);
    send_run(1'b0, 8'h01, ESCAPE_BYTE);
    send_run(1'b0, ESCAPE_BYTE, 8'h00);
    // a new block cuts off a pending run and a pending escape
    send_request(ESCAPE_BYTE, 1'b0);
    send_request(ESCAPE_BYTE, 1'b0);
    send_request(8'h05, 1'b0);
    send_request(8'h42, 1'b1);
    send_request(ESCAPE_BYTE, 1'b0);
    send_request(8'h11, 1'b1);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      if (p / 3 == 1) begin
        send_idle_pct = 47;
        recv_idle_pct = 16;
      end else if (p / 3 == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_block_length(lengths[p]);
      send_random_stream(ITEMS_PER_PHASE);
      settle();
    end
    repeat (20) @(posedge clk);

    $display("sent %0d requests (%0d runs) over %0d block lengths", requests_sent, runs_sent,
             PHASES + 1);
    $display("checked %0d results, %0d with block done, %0d mismatches", sb.results_seen,
             sb.done_seen, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== escape_rle_byte_decoder_top.f =====
rtl/core/erle_pkg.sv
rtl/core/erle_ifs.sv
rtl/core/erle_ctrl.sv
rtl/core/erle_dp.sv
rtl/core/escape_rle_byte_decoder_top.sv
bench/escape_rle_byte_decoder_top_tb.sv
